[rtl/core/esd_pkg.sv]
package esd_pkg;

   localparam int unsigned CharWidth = 21;
   localparam int unsigned CodeWidth = 32;

   typedef struct packed {
      logic [CharWidth-1:0] char_in;
      logic                 is_last;
   } esd_req_type;

   typedef struct packed {
      logic                 char_valid;
      logic [CodeWidth-1:0] code_out;
      logic                 end_of_string;
   } esd_rsp_type;

   typedef logic [1:0] esd_phase_type;

   localparam esd_phase_type PHASE_TEXT = 2'd0;
   localparam esd_phase_type PHASE_ESC  = 2'd1;
   localparam esd_phase_type PHASE_HEX  = 2'd2;

   localparam logic [CharWidth-1:0] CH_BACKSLASH = 21'h00005C;
   localparam logic [CharWidth-1:0] CH_U         = 21'h000075;
   localparam logic [CharWidth-1:0] CH_B         = 21'h000062;
   localparam logic [CharWidth-1:0] CH_F         = 21'h000066;
   localparam logic [CharWidth-1:0] CH_N         = 21'h00006E;
   localparam logic [CharWidth-1:0] CH_R         = 21'h000072;
   localparam logic [CharWidth-1:0] CH_T         = 21'h000074;
   localparam logic [CharWidth-1:0] CH_E         = 21'h000065;
   localparam logic [CharWidth-1:0] CH_ZERO      = 21'h000030;
   localparam logic [CharWidth-1:0] CH_LOWER_A   = 21'h000061;
   localparam logic [CharWidth-1:0] CH_LOWER_Z   = 21'h00007A;
   localparam logic [CharWidth-1:0] CH_UPPER_A   = 21'h000041;
   localparam logic [CharWidth-1:0] CH_UPPER_Z   = 21'h00005A;

   localparam logic [CodeWidth-1:0] CODE_BS  = 32'h08;
   localparam logic [CodeWidth-1:0] CODE_FF  = 32'h0C;
   localparam logic [CodeWidth-1:0] CODE_LF  = 32'h0A;
   localparam logic [CodeWidth-1:0] CODE_CR  = 32'h0D;
   localparam logic [CodeWidth-1:0] CODE_TAB = 32'h09;
   localparam logic [CodeWidth-1:0] CODE_ESC = 32'h1B;
   localparam logic [CodeWidth-1:0] CODE_NUL = 32'h00;

   function automatic logic [CodeWidth-1:0] escape_value(input logic [CharWidth-1:0] c);
      logic [CodeWidth-1:0] v;
      unique case (c)
         CH_B:    v = CODE_BS;
         CH_F:    v = CODE_FF;
         CH_N:    v = CODE_LF;
         CH_R:    v = CODE_CR;
         CH_T:    v = CODE_TAB;
         CH_E:    v = CODE_ESC;
         CH_ZERO: v = CODE_NUL;
         default: v = {{(CodeWidth-CharWidth){1'b0}}, c};
      endcase
      return v;
   endfunction

   // letters count from a/A plus 10, anything else from '0' with wraparound
   function automatic logic [CodeWidth-1:0] digit_value(input logic [CharWidth-1:0] c);
      logic [CodeWidth-1:0] cw;
      logic [CodeWidth-1:0] v;
      cw = {{(CodeWidth-CharWidth){1'b0}}, c};
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         v = cw - {{(CodeWidth-CharWidth){1'b0}}, CH_LOWER_A} + 32'd10;
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         v = cw - {{(CodeWidth-CharWidth){1'b0}}, CH_UPPER_A} + 32'd10;
      end else begin
         v = cw - {{(CodeWidth-CharWidth){1'b0}}, CH_ZERO};
      end
      return v;
   endfunction

endpackage

[rtl/core/escape_sequence_decoder.sv]
// Channel  | Ports                            | Direction
// ---------+----------------------------------+----------
// request  | req_valid, req_ready, req_data   | in
// response | rsp_valid, rsp_ready, rsp_data   | out
//
// One character per cycle sustained while rsp_ready stays high; each transaction
// is held in the input register, then in the result register that drives the response.
// The decode state updates when a character moves from the input register
// into the result register, so a stalled response holds the state too.
// Synchronous reset empties both registers and returns the decode state to
// normal text. While a response waits, an empty input register takes one
// transaction and then holds it until the response is taken.
module escape_sequence_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  esd_pkg::esd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output esd_pkg::esd_rsp_type rsp_data
);
   import esd_pkg::*;

   logic                 in_valid_ff;
   esd_req_type          in_data_ff;
   logic                 out_valid_ff, out_valid_in;
   esd_rsp_type          out_data_ff, out_data_in;

   esd_phase_type        phase_ff, phase_in;
   logic [1:0]           left_ff, left_in;
   logic [CodeWidth-1:0] acc_ff, acc_in;

   logic                 advance;
   logic [CodeWidth-1:0] term;
   logic [CodeWidth-1:0] hex_sum;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign term    = digit_value(in_data_ff.char_in) << {left_ff, 2'b00};
   assign hex_sum = acc_ff + term;

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      acc_in   = acc_ff;
      out_data_in.char_valid    = 1'b0;
      out_data_in.code_out      = '0;
      out_data_in.end_of_string = in_data_ff.is_last;

      unique case (phase_ff)
         PHASE_ESC: begin
            if (in_data_ff.char_in == CH_U) begin
               phase_in = PHASE_HEX;
               left_in  = 2'd3;
               acc_in   = '0;
               out_data_in.char_valid = in_data_ff.is_last;
            end else begin
               phase_in = PHASE_TEXT;
               out_data_in.char_valid = 1'b1;
               out_data_in.code_out   = escape_value(in_data_ff.char_in);
            end
         end
         PHASE_HEX: begin
            if (left_ff == 2'd0 || in_data_ff.is_last) begin
               out_data_in.char_valid = 1'b1;
               out_data_in.code_out   = hex_sum;
               phase_in = PHASE_TEXT;
               left_in  = 2'd0;
               acc_in   = '0;
            end else begin
               acc_in  = hex_sum;
               left_in = left_ff - 2'd1;
            end
         end
         default: begin
            // unused phase code behaves as normal text
            phase_in = PHASE_TEXT;
            if (in_data_ff.char_in == CH_BACKSLASH) begin
               phase_in = PHASE_ESC;
            end else begin
               out_data_in.char_valid = 1'b1;
               out_data_in.code_out   = {{(CodeWidth-CharWidth){1'b0}}, in_data_ff.char_in};
            end
         end
      endcase

      if (in_data_ff.is_last) begin
         phase_in = PHASE_TEXT;
         left_in  = 2'd0;
         acc_in   = '0;
      end

      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PHASE_TEXT;
         left_ff      <= 2'd0;
         acc_ff       <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
            acc_ff   <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.is_last |=> phase_ff == PHASE_TEXT && left_ff == 2'd0
                                         && acc_ff == '0)
      else $error("decode state not cleared after end of string");

   a_idle_hex_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PHASE_HEX |-> acc_ff == '0 && left_ff == 2'd0)
      else $error("hex state live outside a hex escape");

   a_invalid_code_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.char_valid |-> out_data_ff.code_out == '0)
      else $error("code unit nonzero on a response without a character");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("held transaction lost from input register");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import esd_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   esd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   esd_rsp_type rsp_data;

   // predicted decode state
   esd_phase_type dec_phase = PHASE_TEXT;
   logic [1:0]    hex_left = 2'd0;
   logic [31:0]   hex_sum = 32'd0;

   esd_rsp_type       expected_units[$];
   logic [20:0]       char_buf[$];
   int                bad_units = 0;
   int                items_sent = 0;
   bit                tx_gaps = 1'b0;
   bit                rx_stalls = 1'b0;

   escape_sequence_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- prediction ----------------

   function automatic logic [31:0] hex_weight(input logic [20:0] ch);
      logic [31:0] wide;
      wide = {11'b0, ch};
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
         return wide - {11'b0, CH_LOWER_A} + 32'd10;
      end
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
         return wide - {11'b0, CH_UPPER_A} + 32'd10;
      end
      // non-letters wrap below '0'
      return wide - {11'b0, CH_ZERO};
   endfunction

   function automatic logic [31:0] unescape_char(input logic [20:0] ch);
      case (ch)
         CH_B:    return CODE_BS;
         CH_F:    return CODE_FF;
         CH_N:    return CODE_LF;
         CH_R:    return CODE_CR;
         CH_T:    return CODE_TAB;
         CH_E:    return CODE_ESC;
         CH_ZERO: return CODE_NUL;
         default: return {11'b0, ch};
      endcase
   endfunction

   function automatic esd_rsp_type decode_char(input esd_req_type req);
      esd_rsp_type decoded;
      decoded = '0;
      decoded.end_of_string = req.is_last;
      case (dec_phase)
         PHASE_ESC: begin
            if (req.char_in == CH_U) begin
               dec_phase = PHASE_HEX;
               hex_left = 2'd3;
               hex_sum = 32'd0;
               // open hex escape at end of string yields a valid zero
               decoded.char_valid = req.is_last;
            end else begin
               dec_phase = PHASE_TEXT;
               decoded.char_valid = 1'b1;
               decoded.code_out = unescape_char(req.char_in);
            end
         end
         PHASE_HEX: begin
            hex_sum = hex_sum + (hex_weight(req.char_in) << (hex_left * 4));
            if (hex_left == 2'd0 || req.is_last) begin
               decoded.char_valid = 1'b1;
               decoded.code_out = hex_sum;
               dec_phase = PHASE_TEXT;
               hex_left = 2'd0;
               hex_sum = 32'd0;
            end else begin
               hex_left = hex_left - 2'd1;
            end
         end
         default: begin
            dec_phase = PHASE_TEXT;
            if (req.char_in == CH_BACKSLASH) begin
               dec_phase = PHASE_ESC;
            end else begin
               decoded.char_valid = 1'b1;
               decoded.code_out = {11'b0, req.char_in};
            end
         end
      endcase
      if (req.is_last) begin
         dec_phase = PHASE_TEXT;
         hex_left = 2'd0;
         hex_sum = 32'd0;
      end
      return decoded;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_units = {expected_units, decode_char(req_data)};
      end
   end

   // ---------------- result checking ----------------

   always @(posedge clock) begin
      esd_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_units.size() == 0) begin
            bad_units++;
            if (bad_units <= 10) begin
               $display("unexpected transaction: valid=%0b code=%h end=%0b",
                        rsp_data.char_valid, rsp_data.code_out, rsp_data.end_of_string);
            end
         end else begin
            want = expected_units.pop_front();
            if (rsp_data.char_valid !== want.char_valid ||
                rsp_data.code_out !== want.code_out ||
                rsp_data.end_of_string !== want.end_of_string) begin
               bad_units++;
               if (bad_units <= 10) begin
                  $display("mismatch: expected valid=%0b code=%h end=%0b, got valid=%0b code=%h end=%0b",
                           want.char_valid, want.code_out, want.end_of_string,
                           rsp_data.char_valid, rsp_data.code_out, rsp_data.end_of_string);
               end
            end
         end
      end
   end

   // receiver back-pressure in random bursts
   always begin
      @(negedge clock);
      if (rx_stalls && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      rsp_ready <= 1'b1;
   end

   // ---------------- stimulus helpers ----------------

   task automatic send_char(input logic [20:0] ch, input logic last);
      @(negedge clock);
      if (tx_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data.char_in <= ch;
      req_data.is_last <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic buf_char(input logic [20:0] ch);
      char_buf = {char_buf, ch};
   endtask

   // send the buffered characters; close marks the final one as end of string
   task automatic flush_buf(input bit close);
      for (int i = 0; i < char_buf.size(); i++) begin
         send_char(char_buf[i], close && (i == char_buf.size() - 1));
      end
      char_buf.delete();
   endtask

   task automatic wait_all_decoded();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_units.size() != 0) @(posedge clock);
   endtask

   function automatic logic [20:0] any_char();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return 21'($urandom_range(32'h20, 32'h7E));
      if (pick < 8) return 21'($urandom_range(0, 32'h1FFFFF));
      if (pick == 8) return CH_BACKSLASH;
      return ($urandom_range(0, 1) != 0) ? 21'h1FFFFF : 21'h10FFFF;
   endfunction

   function automatic logic [20:0] hex_char();
      int d;
      int pick;
      pick = $urandom_range(0, 9);
      d = $urandom_range(0, 15);
      if (pick < 7) begin
         if (d < 10) return CH_ZERO + 21'(d);
         return (($urandom_range(0, 1) != 0) ? CH_LOWER_A : CH_UPPER_A) + 21'(d - 10);
      end
      if (pick == 7) begin
         // letters past f still count from a or A
         return (($urandom_range(0, 1) != 0) ? CH_LOWER_A : CH_UPPER_A)
                + 21'($urandom_range(6, 25));
      end
      return any_char();
   endfunction

   function automatic logic [20:0] escape_letter();
      logic [20:0] letters[11];
      letters = '{CH_B, CH_F, CH_N, CH_R, CH_T, CH_E, CH_ZERO, CH_BACKSLASH,
                  21'h22, 21'h27, 21'h2F};
      if ($urandom_range(0, 4) == 0) return any_char();
      return letters[4'($urandom_range(0, 10))];
   endfunction

   // ---------------- tests ----------------

   task automatic test_plain_text();
      buf_char(21'h1FFFFF);
      buf_char(21'h000000);
      flush_buf(1'b1);
   endtask

   task automatic test_simple_escapes();
      logic [20:0] letters[9];
      letters = '{CH_B, CH_F, CH_N, CH_R, CH_T, CH_E, CH_ZERO, CH_BACKSLASH, 21'h2F};
      foreach (letters[i]) begin
         buf_char(CH_BACKSLASH);
         buf_char(letters[i]);
      end
      flush_buf(1'b1);
   endtask

   task automatic test_hex_escapes();
      buf_char(CH_BACKSLASH);
      buf_char(CH_U);
      buf_char(21'h1FFFFF);
      buf_char(CH_LOWER_A);
      buf_char(CH_UPPER_Z);
      buf_char(CH_ZERO);
      flush_buf(1'b1);
   endtask

   task automatic test_open_sequences();
      // hex escape cut right after the u
      buf_char(CH_BACKSLASH);
      buf_char(CH_U);
      flush_buf(1'b1);
      // hex escape cut after one digit
      buf_char(CH_BACKSLASH);
      buf_char(CH_U);
      buf_char(CH_UPPER_A + 21'd5);
      flush_buf(1'b1);
      // lone trailing backslash
      buf_char(CH_BACKSLASH);
      flush_buf(1'b1);
   endtask

   task automatic test_random_mixed(input int n_items);
      int stop_at;
      int tokens;
      int sel;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: raw characters with random end marks
            repeat ($urandom_range(1, 6)) begin
               send_char(($urandom_range(0, 3) == 0) ? CH_U : any_char(),
                         1'($urandom_range(0, 1)));
            end
         end else begin
            tokens = $urandom_range(1, 6);
            repeat (tokens) begin
               sel = $urandom_range(0, 99);
               if (sel < 40) begin
                  buf_char(any_char());
               end else if (sel < 65) begin
                  buf_char(CH_BACKSLASH);
                  buf_char(escape_letter());
               end else if (sel < 92) begin
                  buf_char(CH_BACKSLASH);
                  buf_char(CH_U);
                  repeat (4) buf_char(hex_char());
               end else begin
                  buf_char(CH_BACKSLASH);
               end
            end
            // sometimes cut up to three characters off the end of the string
            if ($urandom_range(0, 4) == 0 && char_buf.size() > 1) begin
               repeat ($urandom_range(1, 3)) begin
                  if (char_buf.size() > 1) void'(char_buf.pop_back());
               end
            end
            flush_buf(1'b1);
         end
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      tx_gaps = 1'b1;
      rx_stalls = 1'b1;
      test_plain_text();
      test_simple_escapes();
      test_hex_escapes();
      test_open_sequences();
      wait_all_decoded();

      test_random_mixed(500);
      tx_gaps = 1'b1;
      rx_stalls = 1'b0;
      test_random_mixed(450);
      wait_all_decoded();
      tx_gaps = 1'b0;
      rx_stalls = 1'b1;
      test_random_mixed(450);
      tx_gaps = 1'b0;
      rx_stalls = 1'b0;
      test_random_mixed(450);

      wait_all_decoded();
      repeat (10) @(posedge clock);
      if (bad_units == 0 && expected_units.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
